@@ src/htr_pkg.sv @@
// ----------------------------------------------------------------------------
// htr_pkg: shared types and constants of the I2C humidity/temperature reader
// Configuration record, decoded measurement record, result record, codes.
// ----------------------------------------------------------------------------
package htr_pkg;

	localparam int TICK_WIDTH  = 16;
	localparam int FRAME_BYTES = 5;
	localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);

	// Register map (index = paddr[3:2])
	localparam int          CFG_ADDR_W     = 4;
	localparam logic [1:0]  REG_SENSOR_ADR = 2'd0;
	localparam logic [1:0]  REG_WRITE_HALF = 2'd1;
	localparam logic [1:0]  REG_READ_HALF  = 2'd2;
	localparam logic [1:0]  REG_ACK_TMO    = 2'd3;

	localparam logic [6:0]  RST_SENSOR_ADR = 7'd92;
	localparam logic [15:0] RST_WRITE_HALF = 16'd15;
	localparam logic [15:0] RST_READ_HALF  = 16'd50;
	localparam logic [15:0] RST_ACK_TMO    = 16'd250;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_ACK   = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;

	// Clamp limits (tenths)
	localparam logic [11:0] HUM_MAX      = 12'd950;
	localparam logic [11:0] HUM_MIN      = 12'd200;
	localparam logic [11:0] TEMP_MAX     = 12'd600;
	localparam logic [11:0] TEMP_MIN_MAG = 12'd200;

	typedef struct packed {
		logic [6:0]  sensor_address;
		logic [15:0] write_half_ticks;
		logic [15:0] read_half_ticks;
		logic [15:0] ack_timeout_ticks;
	} htr_cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [10:0] temperature_tenths;
		logic [9:0]         humidity_tenths;
	} htr_meas_t;

	typedef struct packed {
		logic      scl_out;
		logic      sda_out;
		logic      busy_res;
		logic      done_res;
		htr_meas_t meas;
	} htr_res_t;

endpackage

@@ src/htr_cfg.sv @@
// ----------------------------------------------------------------------------
// htr_cfg: APB register file
// Four configuration registers, written on the access phase, read back.
// ----------------------------------------------------------------------------
module htr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [htr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output htr_pkg::htr_cfg_t              cfg
);

	htr_pkg::htr_cfg_t cfg_q;
	logic [1:0]        reg_idx;
	logic              wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_address    <= htr_pkg::RST_SENSOR_ADR;
			cfg_q.write_half_ticks  <= htr_pkg::RST_WRITE_HALF;
			cfg_q.read_half_ticks   <= htr_pkg::RST_READ_HALF;
			cfg_q.ack_timeout_ticks <= htr_pkg::RST_ACK_TMO;
		end else if (wr_en) begin
			case (reg_idx)
				htr_pkg::REG_SENSOR_ADR: cfg_q.sensor_address    <= pwdata[6:0];
				htr_pkg::REG_WRITE_HALF: cfg_q.write_half_ticks  <= pwdata[15:0];
				htr_pkg::REG_READ_HALF:  cfg_q.read_half_ticks   <= pwdata[15:0];
				htr_pkg::REG_ACK_TMO:    cfg_q.ack_timeout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			htr_pkg::REG_SENSOR_ADR: prdata = {25'd0, cfg_q.sensor_address};
			htr_pkg::REG_WRITE_HALF: prdata = {16'd0, cfg_q.write_half_ticks};
			htr_pkg::REG_READ_HALF:  prdata = {16'd0, cfg_q.read_half_ticks};
			htr_pkg::REG_ACK_TMO:    prdata = {16'd0, cfg_q.ack_timeout_ticks};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

@@ src/htr_decode.sv @@
// ----------------------------------------------------------------------------
// htr_decode: frame decoder
// Checksum test, humidity and temperature in tenths with clamping.
// ----------------------------------------------------------------------------
module htr_decode (
	input  logic [htr_pkg::FRAME_BYTES-1:0][7:0] frame,
	input  logic                                 lost_ack,
	output htr_pkg::htr_meas_t                   meas
);

	logic [7:0]  sum;
	logic [11:0] hum_raw;
	logic [11:0] mag;
	logic [11:0] neg;
	logic [9:0]  hum;
	logic [10:0] temp;

	assign sum     = frame[0] + frame[1] + frame[2] + frame[3];
	assign hum_raw = 12'(frame[0]) * 12'd10 + 12'(frame[1]);
	assign mag     = 12'(frame[2]) * 12'd10 + {5'd0, frame[3][6:0]};
	assign neg     = 12'd0 - mag;

	always_comb begin
		if (hum_raw > htr_pkg::HUM_MAX)
			hum = htr_pkg::HUM_MAX[9:0];
		else if (hum_raw < htr_pkg::HUM_MIN)
			hum = htr_pkg::HUM_MIN[9:0];
		else
			hum = hum_raw[9:0];

		// bit 7 of the fraction byte is the sign of a sign-magnitude value
		if (frame[3][7]) begin
			if (mag > htr_pkg::TEMP_MIN_MAG)
				temp = 11'(12'd0 - htr_pkg::TEMP_MIN_MAG);
			else
				temp = neg[10:0];
		end else if (mag > htr_pkg::TEMP_MAX) begin
			temp = htr_pkg::TEMP_MAX[10:0];
		end else begin
			temp = mag[10:0];
		end

		if (lost_ack) begin
			meas.status             = htr_pkg::ST_NO_ACK;
			meas.temperature_tenths = '0;
			meas.humidity_tenths    = '0;
		end else if (frame[4] != sum) begin
			meas.status             = htr_pkg::ST_CHECKSUM;
			meas.temperature_tenths = '0;
			meas.humidity_tenths    = '0;
		end else begin
			meas.status             = htr_pkg::ST_OK;
			meas.temperature_tenths = $signed(temp);
			meas.humidity_tenths    = hum;
		end
	end

endmodule

@@ src/htr_ctrl.sv @@
// ----------------------------------------------------------------------------
// htr_ctrl: bus sequencer
// One tick per step: I2C phase machine, bit timing, frame capture, held result.
// ----------------------------------------------------------------------------
module htr_ctrl #(
	parameter int TICK_WIDTH = htr_pkg::TICK_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              sda_in,
	input  logic              start_request,
	input  htr_pkg::htr_cfg_t cfg,
	output htr_pkg::htr_res_t res
);

	localparam int CW = ((TICK_WIDTH > 16) ? TICK_WIDTH : 16) + 1;
	localparam logic [CW-1:0] TICK_MAX = CW'((64'd1 << TICK_WIDTH) - 64'd1);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_START_A  = 4'd1;
	localparam logic [3:0] PH_START_B  = 4'd2;
	localparam logic [3:0] PH_WR_LOW   = 4'd3;
	localparam logic [3:0] PH_WR_HIGH  = 4'd4;
	localparam logic [3:0] PH_ACK_LOW  = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH = 4'd6;
	localparam logic [3:0] PH_ACK_POLL = 4'd7;
	localparam logic [3:0] PH_ACK_TAIL = 4'd8;
	localparam logic [3:0] PH_RD_LOW   = 4'd9;
	localparam logic [3:0] PH_RD_HIGH  = 4'd10;
	localparam logic [3:0] PH_MA_LOW   = 4'd11;
	localparam logic [3:0] PH_MA_HIGH  = 4'd12;
	localparam logic [3:0] PH_STOP_A   = 4'd13;
	localparam logic [3:0] PH_STOP_B   = 4'd14;
	localparam logic [3:0] PH_FINISH   = 4'd15;

	localparam logic [2:0] LAST_BYTE = 3'(htr_pkg::FRAME_BYTES - 1);

	logic [3:0]            phase_q, phase_d;
	logic [TICK_WIDTH-1:0] tick_q, tick_d;
	logic [2:0]            bit_q, bit_d;
	logic [2:0]            byte_q, byte_d;
	logic [7:0]            shift_q, shift_d;
	logic                  lost_q, lost_d;
	htr_pkg::htr_meas_t    held_q, held_d;
	htr_pkg::htr_meas_t    dec_meas;

	logic [htr_pkg::FRAME_BYTES-1:0][7:0] frame_q;
	logic                                 frame_we;
	logic [htr_pkg::FRAME_IDX_W-1:0]      frame_idx;

	logic [CW-1:0] lim_wr, lim_rd, lim_ack, tick_inc;
	logic          wr_over, rd_over, ack_expired, nack;
	logic [7:0]    rd_shifted, adr_byte;
	logic [TICK_WIDTH-1:0] tick_wr, tick_rd;
	logic          scl_o, sda_o, busy_o, done_o;

	// Half-period limit: zero acts as one, above the counter range saturates
	function automatic logic [CW-1:0] eff_ticks(input logic [15:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		if (v == 16'd0)
			eff_ticks = CW'(1);
		else if (w > TICK_MAX)
			eff_ticks = TICK_MAX;
		else
			eff_ticks = w;
	endfunction

	assign lim_wr   = eff_ticks(cfg.write_half_ticks);
	assign lim_rd   = eff_ticks(cfg.read_half_ticks);
	assign lim_ack  = (cfg.ack_timeout_ticks == 16'd0) ? '0 : eff_ticks(cfg.ack_timeout_ticks);
	assign tick_inc = CW'(tick_q) + CW'(1);
	assign wr_over  = tick_inc >= lim_wr;
	assign rd_over  = tick_inc >= lim_rd;
	assign tick_wr  = wr_over ? '0 : tick_inc[TICK_WIDTH-1:0];
	assign tick_rd  = rd_over ? '0 : tick_inc[TICK_WIDTH-1:0];
	assign ack_expired = CW'(tick_q) >= lim_ack;
	assign nack     = byte_q >= LAST_BYTE;
	assign rd_shifted = {shift_q[6:0], sda_in};
	assign adr_byte = {cfg.sensor_address, (byte_q != 3'd0)};
	assign frame_idx = (byte_q < 3'(htr_pkg::FRAME_BYTES)) ? byte_q[htr_pkg::FRAME_IDX_W-1:0]
	                                                       : LAST_BYTE[htr_pkg::FRAME_IDX_W-1:0];

	htr_decode u_decode (
		.frame    (frame_q),
		.lost_ack (lost_q),
		.meas     (dec_meas)
	);

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		shift_d  = shift_q;
		lost_d   = lost_q;
		held_d   = held_q;
		frame_we = 1'b0;
		scl_o    = 1'b1;
		sda_o    = 1'b1;
		busy_o   = 1'b1;
		done_o   = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				busy_o = 1'b0;
				if (start_request) begin
					phase_d = PH_START_A;
					tick_d  = '0;
					bit_d   = '0;
					byte_d  = '0;
					lost_d  = 1'b0;
				end
			end
			PH_START_A: begin
				tick_d = tick_wr;
				if (wr_over)
					phase_d = PH_START_B;
			end
			PH_START_B: begin
				sda_o  = 1'b0;
				tick_d = tick_wr;
				if (wr_over) begin
					shift_d = adr_byte;
					bit_d   = '0;
					phase_d = PH_WR_LOW;
				end
			end
			PH_WR_LOW: begin
				scl_o  = 1'b0;
				sda_o  = shift_q[7];
				tick_d = tick_wr;
				if (wr_over)
					phase_d = PH_WR_HIGH;
			end
			PH_WR_HIGH: begin
				sda_o  = shift_q[7];
				tick_d = tick_wr;
				if (wr_over) begin
					shift_d = {shift_q[6:0], 1'b0};
					if (bit_q == 3'd7) begin
						bit_d   = '0;
						phase_d = PH_ACK_LOW;
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_WR_LOW;
					end
				end
			end
			PH_ACK_LOW: begin
				scl_o  = 1'b0;
				tick_d = tick_wr;
				if (wr_over)
					phase_d = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				tick_d = tick_wr;
				if (wr_over)
					phase_d = PH_ACK_POLL;
			end
			PH_ACK_POLL: begin
				if (!sda_in) begin
					tick_d  = '0;
					phase_d = PH_ACK_TAIL;
				end else if (ack_expired) begin
					tick_d = '0;
					// only the first address byte aborts; later misses are tolerated
					if (byte_q == 3'd0) begin
						lost_d  = 1'b1;
						phase_d = PH_STOP_A;
					end else begin
						phase_d = PH_ACK_TAIL;
					end
				end else begin
					tick_d = tick_inc[TICK_WIDTH-1:0];
				end
			end
			PH_ACK_TAIL: begin
				scl_o  = 1'b0;
				tick_d = tick_wr;
				if (wr_over) begin
					if (byte_q == 3'd0) begin
						byte_d  = 3'd1;
						shift_d = '0;
						bit_d   = '0;
						phase_d = PH_WR_LOW;
					end else if (byte_q == 3'd1) begin
						byte_d  = 3'd2;
						phase_d = PH_START_A;
					end else begin
						byte_d  = '0;
						bit_d   = '0;
						shift_d = '0;
						phase_d = PH_RD_LOW;
					end
				end
			end
			PH_RD_LOW: begin
				scl_o  = 1'b0;
				tick_d = tick_rd;
				if (rd_over)
					phase_d = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				tick_d = tick_rd;
				if (rd_over) begin
					shift_d = rd_shifted;
					if (bit_q == 3'd7) begin
						bit_d    = '0;
						frame_we = 1'b1;
						phase_d  = PH_MA_LOW;
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_RD_LOW;
					end
				end
			end
			PH_MA_LOW: begin
				scl_o  = 1'b0;
				sda_o  = nack;
				tick_d = tick_wr;
				if (wr_over)
					phase_d = PH_MA_HIGH;
			end
			PH_MA_HIGH: begin
				sda_o  = nack;
				tick_d = tick_wr;
				if (wr_over) begin
					if (nack) begin
						phase_d = PH_STOP_A;
					end else begin
						byte_d  = byte_q + 3'd1;
						shift_d = '0;
						phase_d = PH_RD_LOW;
					end
				end
			end
			PH_STOP_A: begin
				scl_o  = 1'b0;
				sda_o  = 1'b0;
				tick_d = tick_wr;
				if (wr_over)
					phase_d = PH_STOP_B;
			end
			PH_STOP_B: begin
				sda_o  = 1'b0;
				tick_d = tick_wr;
				if (wr_over) begin
					held_d  = dec_meas;
					phase_d = PH_FINISH;
				end
			end
			default: begin
				busy_o  = 1'b0;
				done_o  = 1'b1;
				phase_d = PH_IDLE;
				tick_d  = '0;
				bit_d   = '0;
				byte_d  = '0;
			end
		endcase
	end

	// the result shows this tick's drive and the held values after the update
	assign res.scl_out  = scl_o;
	assign res.sda_out  = sda_o;
	assign res.busy_res = busy_o;
	assign res.done_res = done_o;
	assign res.meas     = held_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			lost_q  <= 1'b0;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			lost_q  <= lost_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && frame_we)
			frame_q[frame_idx] <= rd_shifted;
	end

endmodule

@@ src/i2c_humidity_temperature_reader_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_humidity_temperature_reader_unit: tick-driven I2C sensor reader
// Input register, one-step bus sequencer, result register; APB configuration.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes the input register, then the result register,
//   before its result beat appears.
// Throughput: one tick beat per cycle while m_axis_tready holds; the sequencer steps once per beat.
// Reset: arst_n clears the stage valid flags and the sequencer (idle, held
//   results zero), loads register defaults; stage data, captured frame bytes stay.
module i2c_humidity_temperature_reader_unit #(
	parameter int TICK_WIDTH = htr_pkg::TICK_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [htr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// tick stream in
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [0] sda_in, [1] start_request
	// result stream out
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata   // [0] scl_out, [1] sda_out,
	                                                       // [2] busy_res, [3] done_res,
	                                                       // [5:4] status,
	                                                       // [16:6] temperature_tenths,
	                                                       // [26:17] humidity_tenths
);

	htr_pkg::htr_cfg_t cfg;
	htr_pkg::htr_res_t res;
	htr_pkg::htr_res_t out_q;

	logic valid_s1;
	logic sda_s1;
	logic req_s1;
	logic out_valid_q;
	logic advance;
	logic step;
	logic in_beat;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	htr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	htr_ctrl #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.sda_in        (sda_s1),
		.start_request (req_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sda_s1 <= s_axis_tdata[0];
			req_s1 <= s_axis_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0,
	                        out_q.meas.humidity_tenths,
	                        out_q.meas.temperature_tenths,
	                        out_q.meas.status,
	                        out_q.done_res,
	                        out_q.busy_res,
	                        out_q.sda_out,
	                        out_q.scl_out};

	// a waiting input beat is never dropped while the result side stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage lost a beat under stall");

	// the finishing beat reports done without busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> !res.busy_res)
		else $error("done raised while busy");

	// lines stay released whenever no transaction runs
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		step && !res.busy_res |-> res.scl_out && res.sda_out)
		else $error("bus driven while idle");

	// an error status always carries zero values
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.meas.status != htr_pkg::ST_OK |->
		res.meas.humidity_tenths == 10'd0 && res.meas.temperature_tenths == 11'sd0)
		else $error("error status with non-zero values");

endmodule
